### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/rqst_pkg.sv
// ---------------------------------------------------------------------------
// rqst_pkg
// Types and constants of the request slot table.
// ---------------------------------------------------------------------------
`default_nettype none

package rqst_pkg;

    localparam int OP_W       = 2;
    localparam int TASK_W     = 16;
    localparam int ADDR_W     = 16;
    localparam int SEL_W      = 3;
    localparam int SLOT_OUT_W = 3;
    localparam int COUNT_W    = 4;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
    localparam logic [OP_W-1:0] OP_COMPACT = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] tid;
        logic [ADDR_W-1:0] paddr;
    } entry_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_ROTATE,
        MODE_SWAP_EVEN,
        MODE_SWAP_ODD
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### design/rqst_if.sv
// ---------------------------------------------------------------------------
// rqst_req_if / rqst_rsp_if
// Valid/ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
`default_nettype none

interface rqst_req_if;
    logic                                valid;
    logic                                ready;
    logic [rqst_pkg::OP_W-1:0]           op;
    logic [rqst_pkg::TASK_W-1:0]         task_id;
    logic [rqst_pkg::ADDR_W-1:0]         proc_addr;
    logic [rqst_pkg::SEL_W-1:0]          slot_sel;

    modport source (output valid, op, task_id, proc_addr, slot_sel, input ready);
    modport sink   (input valid, op, task_id, proc_addr, slot_sel, output ready);
endinterface

interface rqst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic [rqst_pkg::SLOT_OUT_W-1:0]     slot_out;
    logic [rqst_pkg::ADDR_W-1:0]         addr_out;
    logic [rqst_pkg::COUNT_W-1:0]        live_count;

    modport source (output valid, ok, slot_out, addr_out, live_count, input ready);
    modport sink   (input valid, ok, slot_out, addr_out, live_count, output ready);
endinterface

`default_nettype wire

### design/rqst_cell.sv
// ---------------------------------------------------------------------------
// rqst_cell
// One table slot: rotates towards the head or swaps with a neighbour so
// that valid entries move forward in order.
// ---------------------------------------------------------------------------
`default_nettype none

module rqst_cell #(
    parameter bit PARITY = 1'b0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rqst_pkg::cell_ctrl_t ctrl,
    input  wire rqst_pkg::entry_t    left_in,
    input  wire rqst_pkg::entry_t    right_in,
    input  wire rqst_pkg::entry_t    rot_in,
    output rqst_pkg::entry_t         q
);

    logic                        valid_reg;
    logic [rqst_pkg::TASK_W-1:0] tid_reg;
    logic [rqst_pkg::ADDR_W-1:0] paddr_reg;
    rqst_pkg::entry_t            entry_cur;
    rqst_pkg::entry_t            entry_next;
    logic                        phase;

    assign entry_cur = '{valid: valid_reg, tid: tid_reg, paddr: paddr_reg};
    assign phase     = (ctrl.mode == rqst_pkg::MODE_SWAP_ODD);

    always_comb
    begin
        entry_next = entry_cur;
        unique case (ctrl.mode)
            rqst_pkg::MODE_HOLD:
            begin
                entry_next = entry_cur;
            end
            rqst_pkg::MODE_ROTATE:
            begin
                entry_next = rot_in;
            end
            rqst_pkg::MODE_SWAP_EVEN, rqst_pkg::MODE_SWAP_ODD:
            begin
                if (PARITY == phase)
                begin
                    // lower of the pair
                    if (!entry_cur.valid && right_in.valid)
                        entry_next = right_in;
                end
                else
                begin
                    // upper of the pair
                    if (!left_in.valid && entry_cur.valid)
                        entry_next = left_in;
                end
            end
            default:
            begin
                entry_next = entry_cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= entry_next.valid;
    end

    always_ff @(posedge clk)
    begin
        tid_reg   <= entry_next.tid;
        paddr_reg <= entry_next.paddr;
    end

    assign q = entry_cur;

endmodule

`default_nettype wire

### design/request_slot_table_top.sv
// ---------------------------------------------------------------------------
// request_slot_table_top
// Table of pending requests: insert, lookup by id, remove, compact.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request word (op, task_id, proc_addr, slot_sel); rsp
//   returns exactly one response word for every request accepted.
//   The slots form a chain of cells. Insert, lookup and remove rotate the
//   chain once through the head, where the head slot is examined and
//   rewritten; compact runs odd-even exchange passes on the valid bits.
//   Either way an operation steps once through every slot, and a new
//   request is not accepted until the current one has finished, since
//   req.ready is low while an operation runs.
//   The response waits in an output register; a stalled receiver holds
//   the next operation on its last step until the register is emptied.
//   The occupancy count is kept in a counter, updated on insert/remove.
//   Reset marks every slot free and empties the output register; no
//   clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module request_slot_table_top #(
    parameter int SLOTS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rqst_req_if.sink    req,
    rqst_rsp_if.source  rsp
);

    localparam int CW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > rqst_pkg::SEL_W) ? CW : rqst_pkg::SEL_W;
    localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

    typedef enum logic {ST_IDLE, ST_BUSY} state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [rqst_pkg::OP_W-1:0]       op_reg, op_next;
    logic [rqst_pkg::TASK_W-1:0]     tid_reg, tid_next;
    logic [rqst_pkg::ADDR_W-1:0]     paddr_reg, paddr_next;
    logic [rqst_pkg::SEL_W-1:0]      sel_reg, sel_next;
    logic                            found_reg, found_next;
    logic [CW-1:0]                   slot_reg, slot_next;
    logic [rqst_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [LW-1:0]                   live_reg, live_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic                            ok_reg, ok_next;
    logic [rqst_pkg::SLOT_OUT_W-1:0] slot_out_reg, slot_out_next;
    logic [rqst_pkg::ADDR_W-1:0]     addr_out_reg, addr_out_next;
    logic [rqst_pkg::COUNT_W-1:0]    live_out_reg, live_out_next;

    logic                  advance;
    logic                  finish;
    rqst_pkg::cell_ctrl_t  ctrl;
    rqst_pkg::entry_t      cell_q [SLOTS];
    rqst_pkg::entry_t      head;
    rqst_pkg::entry_t      wrap;
    logic                  found_step;
    logic [CW-1:0]         slot_step;
    logic [rqst_pkg::ADDR_W-1:0] addr_step;
    logic [LW-1:0]         live_step;

    localparam rqst_pkg::entry_t EDGE_VALID   = '{valid: 1'b1, tid: '0, paddr: '0};
    localparam rqst_pkg::entry_t EDGE_INVALID = '{valid: 1'b0, tid: '0, paddr: '0};

    // cell chain
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        rqst_pkg::entry_t left_e;
        rqst_pkg::entry_t right_e;
        rqst_pkg::entry_t rot_e;

        if (i == 0)
        begin : g_first
            assign left_e = EDGE_VALID;
        end
        else
        begin : g_mid_l
            assign left_e = cell_q[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign right_e = EDGE_INVALID;
            assign rot_e   = wrap;
        end
        else
        begin : g_mid_r
            assign right_e = cell_q[i+1];
            assign rot_e   = cell_q[i+1];
        end

        rqst_cell #(
            .PARITY (1'(i % 2))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .left_in  (left_e),
            .right_in (right_e),
            .rot_in   (rot_e),
            .q        (cell_q[i])
        );
    end

    assign head    = cell_q[0];
    assign advance = (state_reg == ST_BUSY) &&
                     ((cnt_reg != LAST) || !rsp_valid_reg || rsp.ready);
    assign finish  = advance && (cnt_reg == LAST);

    always_comb
    begin
        ctrl.mode = rqst_pkg::MODE_HOLD;
        if (advance)
        begin
            if (op_reg == rqst_pkg::OP_COMPACT)
                ctrl.mode = cnt_reg[0] ? rqst_pkg::MODE_SWAP_ODD : rqst_pkg::MODE_SWAP_EVEN;
            else
                ctrl.mode = rqst_pkg::MODE_ROTATE;
        end
    end

    // head slot processing during rotation
    always_comb
    begin
        wrap       = head;
        found_step = found_reg;
        slot_step  = slot_reg;
        addr_step  = addr_reg;
        live_step  = live_reg;
        unique case (op_reg)
            rqst_pkg::OP_INSERT:
            begin
                if (!found_reg && !head.valid)
                begin
                    wrap.valid = 1'b1;
                    wrap.tid   = tid_reg;
                    wrap.paddr = paddr_reg;
                    found_step = 1'b1;
                    slot_step  = cnt_reg;
                    live_step  = live_reg + LW'(1);
                end
            end
            rqst_pkg::OP_LOOKUP:
            begin
                if (!found_reg && head.valid && (head.tid == tid_reg))
                begin
                    found_step = 1'b1;
                    slot_step  = cnt_reg;
                    addr_step  = head.paddr;
                end
            end
            rqst_pkg::OP_REMOVE:
            begin
                if (CMPW'(cnt_reg) == CMPW'(sel_reg))
                begin
                    wrap.valid = 1'b0;
                    if (head.valid)
                        live_step = live_reg - LW'(1);
                end
            end
            default:
            begin
                wrap = head;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        paddr_next     = paddr_reg;
        sel_next       = sel_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        addr_next      = addr_reg;
        live_next      = live_reg;
        rsp_valid_next = rsp_valid_reg;
        ok_next        = ok_reg;
        slot_out_next  = slot_out_reg;
        addr_out_next  = addr_out_reg;
        live_out_next  = live_out_reg;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_BUSY;
                    cnt_next   = '0;
                    op_next    = req.op;
                    tid_next   = req.task_id;
                    paddr_next = req.proc_addr;
                    sel_next   = req.slot_sel;
                    found_next = 1'b0;
                    slot_next  = '0;
                    addr_next  = '0;
                end
            end
            ST_BUSY:
            begin
                if (advance)
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    found_next = found_step;
                    slot_next  = slot_step;
                    addr_next  = addr_step;
                    live_next  = live_step;
                end
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    ok_next        = found_step;
                    slot_out_next  = rqst_pkg::SLOT_OUT_W'(slot_step);
                    addr_out_next  = addr_step;
                    live_out_next  = (op_reg == rqst_pkg::OP_COMPACT) ?
                                     rqst_pkg::COUNT_W'(live_reg) : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= rqst_pkg::OP_INSERT;
            tid_reg       <= '0;
            paddr_reg     <= '0;
            sel_reg       <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            addr_reg      <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            slot_out_reg  <= '0;
            addr_out_reg  <= '0;
            live_out_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            tid_reg       <= tid_next;
            paddr_reg     <= paddr_next;
            sel_reg       <= sel_next;
            found_reg     <= found_next;
            slot_reg      <= slot_next;
            addr_reg      <= addr_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
            ok_reg        <= ok_next;
            slot_out_reg  <= slot_out_next;
            addr_out_reg  <= addr_out_next;
            live_out_reg  <= live_out_next;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.slot_out   = slot_out_reg;
    assign rsp.addr_out   = addr_out_reg;
    assign rsp.live_count = live_out_reg;

endmodule

`default_nettype wire

### design/rqst_checker.sv
// ---------------------------------------------------------------------------
// rqst_checker
// Port-level checks of the request slot table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rqst_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                req_valid,
    input wire logic                                req_ready,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic                                rsp_ok,
    input wire logic [rqst_pkg::SLOT_OUT_W-1:0]     rsp_slot_out,
    input wire logic [rqst_pkg::ADDR_W-1:0]         rsp_addr_out,
    input wire logic [rqst_pkg::COUNT_W-1:0]        rsp_live_count
);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_IMPLY(a_miss_zero, clk, rst_n, rsp_valid && !rsp_ok, (rsp_slot_out == '0) && (rsp_addr_out == '0))
    `ASSERT_IMPLY(a_count_only_compact, clk, rst_n, rsp_valid && (rsp_live_count != '0), !rsp_ok)

endmodule

bind request_slot_table_top rqst_checker u_rqst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_slot_out   (rsp.slot_out),
    .rsp_addr_out   (rsp.addr_out),
    .rsp_live_count (rsp.live_count)
);

`default_nettype wire
